### sv/clnw_pkg.sv
`default_nettype none

package clnw_pkg;

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_DATA = 2'd1,
        REQ_MOVE = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        PH_SETUP_HI  = 3'd0,
        PH_STROBE_HI = 3'd1,
        PH_SETUP_LO  = 3'd2,
        PH_STROBE_LO = 3'd3,
        PH_RELEASE   = 3'd4
    } t_phase;

    localparam logic CFG_SETUP_DELAY = 1'b0;
    localparam logic CFG_STROBE      = 1'b1;

    localparam logic [7:0] SETUP_DELAY_RESET = 8'd4;
    localparam logic [7:0] STROBE_RESET      = 8'd5;

    localparam logic [7:0] CMD_ROW0 = 8'h80;
    localparam logic [7:0] CMD_ROW1 = 8'hC0;

    localparam logic HOLD_TICKS = 1'b0;
    localparam logic HOLD_MS    = 1'b1;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       rs;
    } t_word;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

### sv/clnw_front.sv
`default_nettype none

module clnw_front (
    input  wire logic [1:0]     i_req_type,
    input  wire logic [7:0]     i_byte_value,
    input  wire logic [3:0]     i_column,
    input  wire logic           i_row,
    output clnw_pkg::t_word     o_word
);

    clnw_pkg::t_req_type req;

    assign req = clnw_pkg::t_req_type'(i_req_type);

    // only bit 1 marks a cursor move, so type three moves too
    always_comb begin
        case (req)
            clnw_pkg::REQ_CMD: begin
                o_word.byte_value = i_byte_value;
                o_word.rs         = 1'b0;
            end
            clnw_pkg::REQ_DATA: begin
                o_word.byte_value = i_byte_value;
                o_word.rs         = 1'b1;
            end
            default: begin
                o_word.byte_value = (i_row ? clnw_pkg::CMD_ROW1 : clnw_pkg::CMD_ROW0)
                                    + {4'd0, i_column};
                o_word.rs         = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/clnw_queue.sv
`default_nettype none

module clnw_queue #(
    parameter int DEPTH = clnw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire clnw_pkg::t_word    i_word,
    input  wire logic               i_pop,
    output clnw_pkg::t_word         o_word,
    output clnw_pkg::t_q_status     o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clnw_pkg::t_word r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_status.empty = (r_count == CNT_W'(0));
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_word         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

`default_nettype wire

### sv/clnw_back.sv
`default_nettype none

module clnw_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_setup_delay_ms,
    input  wire logic [7:0]         i_strobe_ticks,
    input  wire clnw_pkg::t_word    i_word,
    input  wire clnw_pkg::t_q_status i_q_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_bus_nibble,
    output logic                    o_reg_select,
    output logic                    o_enable_line,
    output logic [7:0]              o_hold_amount,
    output logic                    o_hold_unit,
    output logic                    o_last_phase
);

    clnw_pkg::t_phase r_phase, n_phase;
    logic             r_valid, n_valid;
    clnw_pkg::t_word  r_word, n_word;
    logic [3:0]       r_cur_nib, n_cur_nib;
    logic             r_cur_rs, n_cur_rs;
    logic             advance;

    assign advance = r_valid && !i_stall;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= clnw_pkg::PH_SETUP_HI;
            r_valid   <= 1'b0;
            r_cur_nib <= 4'd0;
            r_cur_rs  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_valid   <= n_valid;
            r_cur_nib <= n_cur_nib;
            r_cur_rs  <= n_cur_rs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    always_comb begin
        n_phase   = r_phase;
        n_valid   = r_valid;
        n_word    = r_word;
        n_cur_nib = r_cur_nib;
        n_cur_rs  = r_cur_rs;
        if (advance) begin
            case (r_phase)
                clnw_pkg::PH_SETUP_HI:  n_phase = clnw_pkg::PH_STROBE_HI;
                clnw_pkg::PH_STROBE_HI: n_phase = clnw_pkg::PH_SETUP_LO;
                clnw_pkg::PH_SETUP_LO:  n_phase = clnw_pkg::PH_STROBE_LO;
                clnw_pkg::PH_STROBE_LO: n_phase = clnw_pkg::PH_RELEASE;
                clnw_pkg::PH_RELEASE: begin
                    n_phase   = clnw_pkg::PH_SETUP_HI;
                    n_valid   = 1'b0;
                    n_cur_nib = r_word.byte_value[3:0];
                    n_cur_rs  = r_word.rs;
                end
                default: n_phase = clnw_pkg::PH_SETUP_HI;
            endcase
        end
        o_pop = (!r_valid || (advance && r_phase == clnw_pkg::PH_RELEASE))
                && !i_q_status.empty;
        if (o_pop) begin
            n_valid = 1'b1;
            n_phase = clnw_pkg::PH_SETUP_HI;
            n_word  = i_word;
        end
    end

    always_comb begin
        o_bus_nibble  = r_word.byte_value[7:4];
        o_reg_select  = r_word.rs;
        o_enable_line = 1'b0;
        o_hold_amount = i_setup_delay_ms;
        o_hold_unit   = clnw_pkg::HOLD_MS;
        o_last_phase  = 1'b0;
        case (r_phase)
            clnw_pkg::PH_SETUP_HI: begin
                // old pins held while the setup wait runs
                o_bus_nibble = r_cur_nib;
                o_reg_select = r_cur_rs;
            end
            clnw_pkg::PH_STROBE_HI: begin
                o_enable_line = 1'b1;
                o_hold_amount = i_strobe_ticks;
                o_hold_unit   = clnw_pkg::HOLD_TICKS;
            end
            clnw_pkg::PH_SETUP_LO: begin
            end
            clnw_pkg::PH_STROBE_LO: begin
                o_bus_nibble  = r_word.byte_value[3:0];
                o_enable_line = 1'b1;
                o_hold_amount = i_strobe_ticks;
                o_hold_unit   = clnw_pkg::HOLD_TICKS;
            end
            clnw_pkg::PH_RELEASE: begin
                o_bus_nibble  = r_word.byte_value[3:0];
                o_hold_amount = 8'd0;
                o_hold_unit   = clnw_pkg::HOLD_TICKS;
                o_last_phase  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != clnw_pkg::PH_SETUP_HI |-> r_valid)
        else $error("phase advanced with no word in flight");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_phase))
        else $error("phase moved under stall");

    a_cur_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == clnw_pkg::PH_RELEASE
        |=> r_cur_nib == $past(r_word.byte_value[3:0]) && r_cur_rs == $past(r_word.rs))
        else $error("bus state not taken from finished word");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_valid || (advance && r_phase == clnw_pkg::PH_RELEASE))
        else $error("pop while a word is mid sequence");

endmodule

`default_nettype wire

### sv/char_lcd_nibble_writer.sv
`default_nettype none

// channel   valid        stall        payload
// in        i_in_valid   o_in_stall   i_req_type i_byte_value i_column i_row
// out       o_out_valid  i_out_stall  o_bus_nibble o_reg_select o_enable_line
//                                     o_hold_amount o_hold_unit o_last_phase
// cfg       i_cfg_we     -            i_cfg_index i_cfg_data
//
// Each word yields five phases, one per cycle while out is not stalled, stepped
// by the single phase sequencer in the back end.
// First phase appears once the word is written into the queue and then popped into the back end's word register.
// A QUEUE_DEPTH word queue decouples in from out; in stalls only when it is full.
// Reset is synchronous, active low; registers return to 4 ms setup, 5 ticks strobe.

module char_lcd_nibble_writer #(
    parameter int QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_byte_value,
    input  wire logic [3:0] i_column,
    input  wire logic       i_row,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_bus_nibble,
    output logic            o_reg_select,
    output logic            o_enable_line,
    output logic [7:0]      o_hold_amount,
    output logic            o_hold_unit,
    output logic            o_last_phase
);

    logic [7:0]          r_setup_delay_ms;
    logic [7:0]          r_strobe_ticks;
    clnw_pkg::t_word     front_word;
    clnw_pkg::t_word     q_word;
    clnw_pkg::t_q_status q_status;
    logic                push;
    logic                pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_delay_ms <= clnw_pkg::SETUP_DELAY_RESET;
            r_strobe_ticks   <= clnw_pkg::STROBE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clnw_pkg::CFG_SETUP_DELAY: r_setup_delay_ms <= i_cfg_data;
                clnw_pkg::CFG_STROBE:      r_strobe_ticks   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_status.full;
    assign push       = i_in_valid && !q_status.full;

    clnw_front u_front (
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_word       (front_word)
    );

    clnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (front_word),
        .i_pop    (pop),
        .o_word   (q_word),
        .o_status (q_status)
    );

    clnw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_setup_delay_ms (r_setup_delay_ms),
        .i_strobe_ticks   (r_strobe_ticks),
        .i_word           (q_word),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_bus_nibble     (o_bus_nibble),
        .o_reg_select     (o_reg_select),
        .o_enable_line    (o_enable_line),
        .o_hold_amount    (o_hold_amount),
        .o_hold_unit      (o_hold_unit),
        .o_last_phase     (o_last_phase)
    );

endmodule

`default_nettype wire
